>>> design/bdxd_pkg.sv
// shared types, codes and a bit function for the bitplane delta/xor decoder
package bdxd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_PLANES = 2'd2;

  // decode modes, any other code acts as delta both then xor
  localparam logic [1:0] MODE_DELTA_BOTH = 2'd0;
  localparam logic [1:0] MODE_DELTA_XOR = 2'd1;
  localparam logic [1:0] MODE_DELTA_BOTH_XOR = 2'd2;

  typedef struct packed {
    logic       mirror_mode;
    logic [1:0] decode_mode;
    logic       swap_planes;
  } cfg_t;

  // bit-reverse each nibble
  function automatic logic [BYTE_W-1:0] nib_flip(input logic [BYTE_W-1:0] v);
    return {v[4], v[5], v[6], v[7], v[0], v[1], v[2], v[3]};
  endfunction

endpackage

>>> design/bdxd_delta.sv
// delta decoder for one bitplane byte with its running bit
module bdxd_delta (
  input  logic [bdxd_pkg::BYTE_W-1:0] raw,
  input  logic                        run_in,
  output logic [bdxd_pkg::BYTE_W-1:0] decoded,
  output logic                        run_out
);

  always_comb begin
    logic r;
    r = run_in;
    decoded = '0;
    for (int i = bdxd_pkg::BYTE_W - 1; i >= 0; i--) begin
      r = r ^ raw[i];
      decoded[i] = r;
    end
    run_out = r;
  end

endmodule

>>> design/bdxd_combine.sv
// plane role selection, mirroring and xor combine
module bdxd_combine (
  input  bdxd_pkg::cfg_t              cfg,
  input  logic [bdxd_pkg::BYTE_W-1:0] raw_a,
  input  logic [bdxd_pkg::BYTE_W-1:0] raw_b,
  input  logic [bdxd_pkg::BYTE_W-1:0] delta_a,
  input  logic [bdxd_pkg::BYTE_W-1:0] delta_b,
  output logic [bdxd_pkg::BYTE_W-1:0] decoded_a,
  output logic [bdxd_pkg::BYTE_W-1:0] decoded_b
);

  logic [bdxd_pkg::BYTE_W-1:0] first_delta;
  logic [bdxd_pkg::BYTE_W-1:0] second_delta;
  logic [bdxd_pkg::BYTE_W-1:0] second_raw;
  logic [bdxd_pkg::BYTE_W-1:0] first_out;
  logic [bdxd_pkg::BYTE_W-1:0] second_mir;
  logic [bdxd_pkg::BYTE_W-1:0] raw_mir;
  logic [bdxd_pkg::BYTE_W-1:0] second_out;

  assign first_delta  = cfg.swap_planes ? delta_b : delta_a;
  assign second_delta = cfg.swap_planes ? delta_a : delta_b;
  assign second_raw   = cfg.swap_planes ? raw_a : raw_b;

  assign first_out  = cfg.mirror_mode ? bdxd_pkg::nib_flip(first_delta) : first_delta;
  assign second_mir = cfg.mirror_mode ? bdxd_pkg::nib_flip(second_delta) : second_delta;
  assign raw_mir    = cfg.mirror_mode ? bdxd_pkg::nib_flip(second_raw) : second_raw;

  always_comb begin
    case (cfg.decode_mode)
      bdxd_pkg::MODE_DELTA_BOTH:     second_out = second_mir;
      bdxd_pkg::MODE_DELTA_XOR:      second_out = raw_mir ^ first_out;
      bdxd_pkg::MODE_DELTA_BOTH_XOR: second_out = second_mir ^ first_out;
      default:                       second_out = second_mir ^ first_out;
    endcase
  end

  assign decoded_a = cfg.swap_planes ? second_out : first_out;
  assign decoded_b = cfg.swap_planes ? first_out : second_out;

endmodule

>>> design/bitplane_delta_xor_decoder_core.sv
// top level of the bitplane delta/xor decoder: input register, decode, result register
//
//   channel  | direction | handshake        | contents
//   s_axis   | in        | tvalid/tready    | tdata: plane_a_byte, plane_b_byte; tuser: row_start
//   m_axis   | out       | tvalid/tready    | tdata: decoded_a, decoded_b
//   cfg      | in        | cfg_we           | cfg_index, cfg_data (no read-back)
//
// one request per cycle sustained while m_axis is not stalled
// decode is one pass of logic between the input register and the result register
// running bits advance when a request moves into the result register
// rst clears valids, running bits and config registers; stalls hold both stages

module bitplane_delta_xor_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bdxd_pkg::DATA_W-1:0]          s_axis_tdata,  // plane_a_byte, plane_b_byte
  input  logic                                 s_axis_tuser,  // row_start
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bdxd_pkg::DATA_W-1:0]          m_axis_tdata,  // decoded_a, decoded_b
  input  logic                                 cfg_we,
  input  logic [bdxd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdxd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bdxd_pkg::cfg_t cfg;

  logic                        in_valid;
  logic [bdxd_pkg::BYTE_W-1:0] in_a;
  logic [bdxd_pkg::BYTE_W-1:0] in_b;
  logic                        in_start;

  logic                        run_a;
  logic                        run_b;
  logic                        run_a_next;
  logic                        run_b_next;

  logic                        out_valid;
  logic [bdxd_pkg::DATA_W-1:0] out_data;

  logic                        advance;
  logic                        base_a;
  logic                        base_b;
  logic [bdxd_pkg::BYTE_W-1:0] delta_a;
  logic [bdxd_pkg::BYTE_W-1:0] delta_b;
  logic                        end_a;
  logic                        end_b;
  logic [bdxd_pkg::BYTE_W-1:0] dec_a;
  logic [bdxd_pkg::BYTE_W-1:0] dec_b;
  logic                        second_frozen;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bdxd_pkg::REG_MIRROR_MODE: cfg.mirror_mode <= cfg_data[0];
        bdxd_pkg::REG_DECODE_MODE: cfg.decode_mode <= cfg_data;
        bdxd_pkg::REG_SWAP_PLANES: cfg.swap_planes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_a     <= s_axis_tdata[bdxd_pkg::BYTE_W-1:0];
      in_b     <= s_axis_tdata[bdxd_pkg::DATA_W-1:bdxd_pkg::BYTE_W];
      in_start <= s_axis_tuser;
    end
  end

  // decode
  assign base_a = in_start ? 1'b0 : run_a;
  assign base_b = in_start ? 1'b0 : run_b;

  bdxd_delta u_delta_a (
    .raw     (in_a),
    .run_in  (base_a),
    .decoded (delta_a),
    .run_out (end_a)
  );

  bdxd_delta u_delta_b (
    .raw     (in_b),
    .run_in  (base_b),
    .decoded (delta_b),
    .run_out (end_b)
  );

  bdxd_combine u_combine (
    .cfg       (cfg),
    .raw_a     (in_a),
    .raw_b     (in_b),
    .delta_a   (delta_a),
    .delta_b   (delta_b),
    .decoded_a (dec_a),
    .decoded_b (dec_b)
  );

  // second plane stream holds its running bit in delta-then-xor mode
  assign second_frozen = (cfg.decode_mode == bdxd_pkg::MODE_DELTA_XOR);
  assign run_a_next    = (second_frozen && cfg.swap_planes) ? base_a : end_a;
  assign run_b_next    = (second_frozen && !cfg.swap_planes) ? base_b : end_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_a <= 1'b0;
      run_b <= 1'b0;
    end else if (advance) begin
      run_a <= run_a_next;
      run_b <= run_b_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {dec_b, dec_a};
    end
  end

endmodule
